// ===== hw/rtl/bvt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and name-encoding functions for the BASIC variable table.
// No dependencies; used by bvt_ctrl, bvt_dp and basic_variable_table.
package bvt_pkg;

	localparam int NAME_W  = 16;
	localparam int VALUE_W = 32;
	localparam int LIMIT_W = 7;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

	localparam logic [7:0] STRING_FLAG = 8'h80;

	// request codes
	localparam logic [2:0] ACT_GET_NUM = 3'd0;
	localparam logic [2:0] ACT_SET_NUM = 3'd1;
	localparam logic [2:0] ACT_GET_STR = 3'd2;
	localparam logic [2:0] ACT_SET_STR = 3'd3;
	localparam logic [2:0] ACT_CLEAR   = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_KIND    = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_SEARCH,
		S_RESP
	} ctrl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic       load_req;
		logic       clear_tab;
		logic       init_scan;
		logic       scan;
		logic       write_hit;
		logic       append;
		logic       res_load;
		logic       res_take_value;
		logic [1:0] res_status;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_clear;
		logic is_set;
		logic bad_req;
		logic kind_ok;
		logic hit;
		logic exhausted;
		logic full;
	} dp_status_t;

	function automatic logic [7:0] upcase(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7A) begin
			r = c - 8'h20;
		end
		return r;
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic [NAME_W-1:0] encode_name(input logic [7:0] c1,
			input logic [7:0] c2, input logic str);
		logic [7:0] lo;
		lo = is_alnum(c2) ? upcase(c2) : 8'h00;
		if (str) begin
			lo = lo | STRING_FLAG;
		end
		return {upcase(c1), lo};
	endfunction

endpackage

// ===== hw/rtl/bvt_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bvt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/bvt_ctrl.sv =====
`timescale 1ns / 1ps
// Request sequencer: decode, linear search, write-back and result strobe.
// Depends on bvt_pkg.
module bvt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  bvt_pkg::dp_status_t dp_st,
	output bvt_pkg::ctrl_cmd_t  cmd,
	output logic                busy,
	output logic                done
);

	bvt_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bvt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			bvt_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load_req = 1'b1;
					state_d      = bvt_pkg::S_DECODE;
				end
			end
			bvt_pkg::S_DECODE: begin
				if (dp_st.is_clear) begin
					cmd.clear_tab  = 1'b1;
					cmd.res_load   = 1'b1;
					cmd.res_status = bvt_pkg::ST_OK;
					state_d        = bvt_pkg::S_RESP;
				end else if (dp_st.bad_req) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = bvt_pkg::ST_KIND;
					state_d        = bvt_pkg::S_RESP;
				end else begin
					cmd.init_scan = 1'b1;
					state_d       = bvt_pkg::S_SEARCH;
				end
			end
			bvt_pkg::S_SEARCH: begin
				cmd.scan = 1'b1;
				if (dp_st.hit) begin
					cmd.res_load = 1'b1;
					state_d      = bvt_pkg::S_RESP;
					if (dp_st.is_set) begin
						cmd.write_hit  = 1'b1;
						cmd.res_status = bvt_pkg::ST_OK;
					end else if (dp_st.kind_ok) begin
						cmd.res_take_value = 1'b1;
						cmd.res_status     = bvt_pkg::ST_OK;
					end else begin
						cmd.res_status = bvt_pkg::ST_KIND;
					end
				end else if (dp_st.exhausted) begin
					cmd.res_load = 1'b1;
					state_d      = bvt_pkg::S_RESP;
					if (!dp_st.is_set) begin
						cmd.res_status = bvt_pkg::ST_MISSING;
					end else if (dp_st.full) begin
						cmd.res_status = bvt_pkg::ST_FULL;
					end else begin
						cmd.append     = 1'b1;
						cmd.res_status = bvt_pkg::ST_OK;
					end
				end
			end
			bvt_pkg::S_RESP: begin
				done    = 1'b1;
				state_d = bvt_pkg::S_IDLE;
			end
			default: begin
				state_d = bvt_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/bvt_dp.sv =====
`timescale 1ns / 1ps
// Table datapath: request registers, name/value RAMs, scan pointer, count, results.
// Depends on bvt_pkg and bvt_ram.
module bvt_dp #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bvt_pkg::ctrl_cmd_t                    cmd,
	output bvt_pkg::dp_status_t                   dp_st,
	input  logic [2:0]                            action,
	input  logic [7:0]                            first_char,
	input  logic [7:0]                            second_char,
	input  logic                                  name_is_string,
	input  logic [31:0]                           write_value,
	input  logic [bvt_pkg::LIMIT_W-1:0]           entry_limit,
	output logic [31:0]                           read_value,
	output logic [1:0]                            status,
	output logic [$clog2(MAX_ENTRIES + 1)-1:0]    entries_used
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int LW = (CW > bvt_pkg::LIMIT_W) ? CW : bvt_pkg::LIMIT_W;

	logic [2:0]                  action_q;
	logic [bvt_pkg::NAME_W-1:0]  code_q;
	logic                        str_q;
	logic [bvt_pkg::VALUE_W-1:0] wval_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] scan_q;
	logic [IW-1:0] cmp_idx_q;
	logic          cmp_vld_q;

	logic [bvt_pkg::NAME_W-1:0]  name_rd;
	logic [bvt_pkg::VALUE_W-1:0] value_rd;

	logic [31:0] read_value_q;
	logic [1:0]  status_q;

	logic                        name_we;
	logic                        value_we;
	logic [IW-1:0]               value_waddr;
	logic                        want_str;
	logic [LW-1:0]               lim_eff;

	// request capture; payload needs no reset
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			action_q <= action;
			code_q   <= bvt_pkg::encode_name(first_char, second_char, name_is_string);
			str_q    <= name_is_string;
			wval_q   <= write_value;
		end
	end

	always_comb begin
		want_str = (action_q == bvt_pkg::ACT_GET_STR) || (action_q == bvt_pkg::ACT_SET_STR);
		dp_st.is_clear = (action_q == bvt_pkg::ACT_CLEAR);
		dp_st.is_set   = (action_q == bvt_pkg::ACT_SET_NUM) ||
			(action_q == bvt_pkg::ACT_SET_STR);
		dp_st.kind_ok  = (str_q == want_str);
		// empty name: upper-casing never maps a non-zero byte to zero
		dp_st.bad_req  = (action_q > bvt_pkg::ACT_CLEAR) || (code_q[15:8] == 8'h00) ||
			(dp_st.is_set && !dp_st.kind_ok);
		dp_st.hit       = cmp_vld_q && (name_rd == code_q);
		dp_st.exhausted = !cmp_vld_q && (scan_q >= count_q);
		lim_eff = (LW'(entry_limit) > LW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) :
			LW'(entry_limit);
		dp_st.full = (LW'(count_q) >= lim_eff);
	end

	// scan pointer: one read a cycle, the compare comes in the cycle after the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			cmp_vld_q <= 1'b0;
			cmp_idx_q <= '0;
		end else if (cmd.init_scan) begin
			scan_q    <= '0;
			cmp_vld_q <= 1'b0;
		end else if (cmd.scan) begin
			if (scan_q < count_q) begin
				scan_q    <= scan_q + 1'b1;
				cmp_vld_q <= 1'b1;
				cmp_idx_q <= scan_q[IW-1:0];
			end else begin
				cmp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear_tab) begin
			count_q <= '0;
		end else if (cmd.append) begin
			count_q <= count_q + 1'b1;
		end
	end

	assign name_we     = cmd.append;
	assign value_we    = cmd.append || cmd.write_hit;
	assign value_waddr = cmd.append ? count_q[IW-1:0] : cmp_idx_q;

	bvt_ram #(
		.WIDTH(bvt_pkg::NAME_W),
		.DEPTH(MAX_ENTRIES)
	) u_names (
		.clk  (clk),
		.we   (name_we),
		.waddr(count_q[IW-1:0]),
		.wdata(code_q),
		.raddr(scan_q[IW-1:0]),
		.rdata(name_rd)
	);

	bvt_ram #(
		.WIDTH(bvt_pkg::VALUE_W),
		.DEPTH(MAX_ENTRIES)
	) u_values (
		.clk  (clk),
		.we   (value_we),
		.waddr(value_waddr),
		.wdata(wval_q),
		.raddr(scan_q[IW-1:0]),
		.rdata(value_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			read_value_q <= cmd.res_take_value ? value_rd : '0;
			status_q     <= cmd.res_status;
		end
	end

	assign read_value   = read_value_q;
	assign status       = status_q;
	assign entries_used = count_q;

endmodule

// ===== hw/rtl/basic_variable_table.sv =====
`timescale 1ns / 1ps
// Top level of the BASIC variable table: APB register, sequencer and datapath.
// Depends on bvt_pkg, bvt_ctrl, bvt_dp (and bvt_ram beneath it).
//
// Usage
//  - Request channel: drive action, first_char, second_char, name_is_string and
//    write_value with start high; the request is taken at an edge where busy is
//    low. busy stays high until the result has been strobed.
//  - Result channel: done is high for exactly one cycle with read_value, status
//    and entries_used valid. The receiver cannot stall; it must sample then.
//  - entry_limit sits at byte address 0 of the APB port (reset 64); write it
//    only while busy is low. Reads return the current limit.
//  - Sequence from the accepting edge: decode, then for a get or set a linear
//    search through the name RAM (one entry a cycle, registered read) that
//    stops at the entry holding the name, then the result state with done
//    high. Clear and rejected requests go from decode to the result state.
//    A name not found (including every append) is compared against all n
//    entries in use before the request. No new request is taken before done;
//    the next request can be taken the cycle after done.
//  - Set writes back in the cycle the search ends, with no separate write state.
//  - Reset: entry count goes to zero and the limit to 64; the RAMs are not
//    cleared, stale entries are simply beyond the count and never compared.
module basic_variable_table #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// APB configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	// request
	input  logic                               start,
	output logic                               busy,
	input  logic [2:0]                         action,
	input  logic [7:0]                         first_char,
	input  logic [7:0]                         second_char,
	input  logic                               name_is_string,
	input  logic [31:0]                        write_value,
	// result
	output logic                               done,
	output logic [31:0]                        read_value,
	output logic [1:0]                         status,
	output logic [$clog2(MAX_ENTRIES + 1)-1:0] entries_used
);

	logic [bvt_pkg::LIMIT_W-1:0] entry_limit_q;
	logic                        limit_sel;
	bvt_pkg::ctrl_cmd_t          cmd;
	bvt_pkg::dp_status_t         dp_st;

	// single register at word 0; paddr[2] set is outside the register map
	assign limit_sel = !paddr[2];
	assign pready    = 1'b1;
	assign prdata    = limit_sel ? 32'(entry_limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_limit_q <= bvt_pkg::LIMIT_RESET;
		end else if (psel && penable && pwrite && limit_sel) begin
			entry_limit_q <= pwdata[bvt_pkg::LIMIT_W-1:0];
		end
	end

	bvt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.dp_st (dp_st),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	bvt_dp #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.dp_st         (dp_st),
		.action        (action),
		.first_char    (first_char),
		.second_char   (second_char),
		.name_is_string(name_is_string),
		.write_value   (write_value),
		.entry_limit   (entry_limit_q),
		.read_value    (read_value),
		.status        (status),
		.entries_used  (entries_used)
	);

	// result strobe lasts a single cycle
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// an accepted request always makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// count never runs past the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entries_used <= ($clog2(MAX_ENTRIES + 1))'(MAX_ENTRIES))
		else $error("entry count beyond table depth");

	// a full or missing result leaves the count as it was
	a_fail_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == bvt_pkg::ST_FULL || status == bvt_pkg::ST_MISSING))
		|-> $stable(entries_used))
		else $error("count changed on a failed request");

endmodule
